// ----- design/rpfd_pkg.sv -----
// ----------------------------------------------------------------------------
// rpfd_pkg
// Shared widths, register indexes and sequencer states for the rate PID core.
// ----------------------------------------------------------------------------
package rpfd_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 31;

    localparam int unsigned McandW = 42;
    localparam int unsigned MplierW = 26;
    localparam int unsigned AccW   = McandW + 1;
    localparam int unsigned ProdW  = AccW + MplierW;

    localparam int unsigned DvdW = 49;
    localparam int unsigned CntW = 6;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_FF_GAIN   = 3'd0,
        CFG_P_GAIN    = 3'd1,
        CFG_I_GAIN    = 3'd2,
        CFG_D_GAIN    = 3'd3,
        CFG_D_COEF    = 3'd4,
        CFG_I_LIMIT   = 3'd5,
        CFG_ERR_LIMIT = 3'd6,
        CFG_THR_MIN   = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_ERRDT,
        ST_DIV,
        ST_MUL_FA,
        ST_MUL_FB,
        ST_MUL_KI,
        ST_MUL_KD,
        ST_MUL_KP,
        ST_MUL_FF,
        ST_FINISH
    } state_t;

endpackage

// ----- design/rate_pid_filtered_derivative_core.sv -----
// ----------------------------------------------------------------------------
// rate_pid_filtered_derivative_core
// One axis rate PID, Q16.16, with clamped integral and low-pass derivative.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  s_       | in        | s_valid / s_ready | target, measured, time step, throttle, armed
//  m_       | out       | m_valid / m_ready | drive, integrating
//  cfg_     | in        | cfg_we            | cfg_index, cfg_wdata
//
// One request runs seven multiplies on the shared shift-add multiplier (one bit
// per cycle), one division on the restoring divider (one quotient bit per
// cycle) and a finish step; the next request is taken only after the finish
// step. The finish step waits while an earlier result is still held, so a
// stalled output stretches the request.
// s_ready is high only between requests; the result register lets the next
// request in while a result waits. Synchronous active-low reset clears the
// state and loads the register defaults.
// ----------------------------------------------------------------------------
module rate_pid_filtered_derivative_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [rpfd_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [rpfd_pkg::CfgDataW-1:0] cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [31:0]            s_target_rate,
    input  logic signed [31:0]            s_measured_rate,
    input  logic [15:0]                   s_time_step,
    input  logic [11:0]                   s_throttle_level,
    input  logic                          s_armed,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [31:0]            m_drive,
    output logic                          m_integrating
);
    import rpfd_pkg::*;

    logic [23:0] kf_reg, ki_reg, kd_reg;
    logic [25:0] kp_reg;
    logic [16:0] coef_reg;
    logic [30:0] ilim_reg, elim_reg;
    logic [11:0] tmin_reg;

    state_t state_reg, state_next;
    logic [CntW-1:0] cnt_reg;

    logic signed [31:0] integral_reg, prev_neg_reg, filt_reg;
    logic signed [31:0] target_reg, measured_reg;
    logic [15:0] dt_reg;
    logic [11:0] thr_reg;
    logic        armed_reg;
    logic signed [32:0] err_reg;
    logic               diff_neg_reg;

    logic signed [McandW-1:0] mcand_reg;
    logic signed [AccW-1:0]   hi_reg;
    logic [MplierW-1:0]       lo_reg;
    logic signed [49:0]       pa_reg;
    logic signed [41:0]       br_reg;
    logic signed [52:0]       pt_reg;
    logic signed [31:0]       drv_reg;

    logic [15:0]     rem_reg;
    logic [DvdW-1:0] dvd_reg;

    logic               m_valid_reg;
    logic signed [31:0] m_drive_reg;
    logic               m_integrating_reg;

    logic last;
    logic out_free;
    logic s_accept;

    // multiplier step
    logic signed [AccW-1:0]  mul_add;
    logic signed [AccW-1:0]  hi_next;
    logic [MplierW-1:0]      lo_next;
    logic signed [ProdW-1:0] prod;
    logic signed [52:0]      prod_sh;

    // divider step
    logic [17:0]     trial;
    logic            ge;
    logic [15:0]     rem_next;
    logic [DvdW-1:0] dvd_next;

    logic signed [33:0] isum, ilim34;
    logic signed [31:0] int_new;
    logic [32:0]        abs_err;
    logic signed [31:0] neg_meas;
    logic signed [32:0] diff;
    logic [32:0]        abs_diff;
    logic [15:0]        dt_eff;
    logic signed [31:0] rate;
    logic [16:0]        coef_c;
    logic [16:0]        coef_inv;
    logic signed [50:0] fsum;
    logic signed [41:0] br_sum;
    logic signed [53:0] dsum;
    logic signed [31:0] dsat;
    logic [31:0]        abs_int;

    assign last     = (cnt_reg == '0);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    assign mul_add = lo_reg[0] ? hi_reg + {mcand_reg[McandW-1], mcand_reg} : hi_reg;
    assign hi_next = {mul_add[AccW-1], mul_add[AccW-1:1]};
    assign lo_next = {mul_add[0], lo_reg[MplierW-1:1]};
    assign prod    = {hi_next, lo_next};
    assign prod_sh = prod[ProdW-1:16];

    assign trial    = {1'b0, rem_reg, dvd_reg[DvdW-1]} - {2'b00, dt_reg};
    assign ge       = !trial[17];
    assign rem_next = ge ? trial[15:0] : {rem_reg[14:0], dvd_reg[DvdW-1]};
    assign dvd_next = {dvd_reg[DvdW-2:0], ge};

    always_comb begin
        isum   = {{2{integral_reg[31]}}, integral_reg} + prod_sh[33:0];
        ilim34 = {3'b000, ilim_reg};
        if (isum > ilim34) begin
            isum = ilim34;
        end
        if (isum < -ilim34) begin
            isum = -ilim34;
        end
        abs_err = err_reg[32] ? 33'(-err_reg) : 33'(err_reg);
        int_new = isum[31:0];
        if ((abs_err > {2'b00, elim_reg}) || (thr_reg < tmin_reg) || !armed_reg) begin
            int_new = '0;
        end

        neg_meas = (measured_reg == 32'sh8000_0000) ? 32'sh7fff_ffff : -measured_reg;
        diff     = {neg_meas[31], neg_meas} - {prev_neg_reg[31], prev_neg_reg};
        abs_diff = diff[32] ? 33'(-diff) : 33'(diff);
        dt_eff   = (s_time_step == '0) ? 16'd1 : s_time_step;

        if (!diff_neg_reg) begin
            rate = (dvd_next > DvdW'(32'h7fff_ffff)) ? 32'sh7fff_ffff
                                                     : 32'(dvd_next);
        end else begin
            rate = (dvd_next > DvdW'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                       : -(32'(dvd_next));
        end

        coef_c   = (coef_reg > 17'h10000) ? 17'h10000 : coef_reg;
        coef_inv = 17'h10000 - coef_c;
        fsum     = {pa_reg[49], pa_reg} + {prod[49], prod[49:0]};
        br_sum   = br_reg + {prod_sh[40], prod_sh[40:0]};
        dsum     = {{13{prod_sh[40]}}, prod_sh[40:0]} + {pt_reg[52], pt_reg};
        if (dsum > 54'sh7fff_ffff) begin
            dsat = 32'sh7fff_ffff;
        end else if (dsum < -54'sh8000_0000) begin
            dsat = 32'sh8000_0000;
        end else begin
            dsat = dsum[31:0];
        end
        abs_int = integral_reg[31] ? 32'(-integral_reg) : 32'(integral_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kf_reg   <= '0;
            kp_reg   <= 26'd2523136;
            ki_reg   <= 24'd33;
            kd_reg   <= 24'd33;
            coef_reg <= 17'd13107;
            ilim_reg <= 31'd196608;
            elim_reg <= 31'd205783;
            tmin_reg <= 12'd100;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_FF_GAIN:   kf_reg   <= cfg_wdata[23:0];
                CFG_P_GAIN:    kp_reg   <= cfg_wdata[25:0];
                CFG_I_GAIN:    ki_reg   <= cfg_wdata[23:0];
                CFG_D_GAIN:    kd_reg   <= cfg_wdata[23:0];
                CFG_D_COEF:    coef_reg <= cfg_wdata[16:0];
                CFG_I_LIMIT:   ilim_reg <= cfg_wdata[30:0];
                CFG_ERR_LIMIT: elim_reg <= cfg_wdata[30:0];
                CFG_THR_MIN:   tmin_reg <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_accept) state_next = ST_MUL_ERRDT;
            ST_MUL_ERRDT: if (last) state_next = ST_DIV;
            ST_DIV:       if (last) state_next = ST_MUL_FA;
            ST_MUL_FA:    if (last) state_next = ST_MUL_FB;
            ST_MUL_FB:    if (last) state_next = ST_MUL_KI;
            ST_MUL_KI:    if (last) state_next = ST_MUL_KD;
            ST_MUL_KD:    if (last) state_next = ST_MUL_KP;
            ST_MUL_KP:    if (last) state_next = ST_MUL_FF;
            ST_MUL_FF:    if (last) state_next = ST_FINISH;
            ST_FINISH:    if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg <= '0;
            prev_neg_reg <= '0;
            filt_reg     <= '0;
            cnt_reg      <= '0;
        end else begin
            if (state_reg != ST_IDLE && state_reg != ST_DIV && state_reg != ST_FINISH
                    && !last) begin
                hi_reg  <= hi_next;
                lo_reg  <= lo_next;
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (state_reg == ST_DIV && !last) begin
                rem_reg <= rem_next;
                dvd_reg <= dvd_next;
                cnt_reg <= cnt_reg - 1'b1;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        target_reg   <= s_target_rate;
                        measured_reg <= s_measured_rate;
                        dt_reg       <= dt_eff;
                        thr_reg      <= s_throttle_level;
                        armed_reg    <= s_armed;
                        err_reg      <= {s_target_rate[31], s_target_rate}
                                      - {s_measured_rate[31], s_measured_rate};
                        mcand_reg    <= McandW'($signed({s_target_rate[31], s_target_rate}
                                      - {s_measured_rate[31], s_measured_rate}));
                        hi_reg       <= '0;
                        lo_reg       <= MplierW'(s_time_step);
                        cnt_reg      <= CntW'(MplierW - 1);
                    end
                end
                ST_MUL_ERRDT: begin
                    if (last) begin
                        integral_reg <= int_new;
                        prev_neg_reg <= neg_meas;
                        diff_neg_reg <= diff[32];
                        rem_reg      <= '0;
                        dvd_reg      <= {abs_diff, 16'h0000};
                        cnt_reg      <= CntW'(DvdW - 1);
                    end
                end
                ST_DIV: begin
                    if (last) begin
                        mcand_reg <= McandW'(rate);
                        hi_reg    <= '0;
                        lo_reg    <= MplierW'(coef_c);
                        cnt_reg   <= CntW'(MplierW - 1);
                    end
                end
                ST_MUL_FA: begin
                    if (last) begin
                        pa_reg    <= prod[49:0];
                        mcand_reg <= McandW'(filt_reg);
                        hi_reg    <= '0;
                        lo_reg    <= MplierW'(coef_inv);
                        cnt_reg   <= CntW'(MplierW - 1);
                    end
                end
                ST_MUL_FB: begin
                    if (last) begin
                        filt_reg  <= fsum[47:16];
                        mcand_reg <= McandW'(integral_reg);
                        hi_reg    <= '0;
                        lo_reg    <= MplierW'(ki_reg);
                        cnt_reg   <= CntW'(MplierW - 1);
                    end
                end
                ST_MUL_KI: begin
                    if (last) begin
                        br_reg    <= 42'(err_reg) + {prod_sh[40], prod_sh[40:0]};
                        mcand_reg <= McandW'(filt_reg);
                        hi_reg    <= '0;
                        lo_reg    <= MplierW'(kd_reg);
                        cnt_reg   <= CntW'(MplierW - 1);
                    end
                end
                ST_MUL_KD: begin
                    if (last) begin
                        mcand_reg <= br_sum;
                        hi_reg    <= '0;
                        lo_reg    <= kp_reg;
                        cnt_reg   <= CntW'(MplierW - 1);
                    end
                end
                ST_MUL_KP: begin
                    if (last) begin
                        pt_reg    <= prod_sh;
                        mcand_reg <= McandW'(target_reg);
                        hi_reg    <= '0;
                        lo_reg    <= MplierW'(kf_reg);
                        cnt_reg   <= CntW'(MplierW - 1);
                    end
                end
                ST_MUL_FF: begin
                    if (last) begin
                        drv_reg <= dsat;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_FINISH && out_free) begin
            m_valid_reg       <= 1'b1;
            m_drive_reg       <= drv_reg;
            m_integrating_reg <= (abs_int >= 32'd3277);
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_drive       = m_drive_reg;
    assign m_integrating = m_integrating_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result without finished request");

    a_mul_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL_KP) |-> (cnt_reg < CntW'(MplierW)))
        else $error("multiplier count out of range");

endmodule

// ----- bench/tb_rate_pid_filtered_derivative_core.sv -----
// ----------------------------------------------------------------------------
// tb_rate_pid_filtered_derivative_core
// Self-checking bench for the one-axis rate PID core. A queue of rate samples
// is fed through a bursty driver; each accepted request is run through an
// in-bench model of the Q16.16 controller and the monitor compares every
// result, under a changing back-pressure pattern, with the oldest prediction.
// Several register settings are visited, the extremes among them.
// ----------------------------------------------------------------------------
module tb_rate_pid_filtered_derivative_core;

    timeunit 1ns;
    timeprecision 1ps;

    import rpfd_pkg::*;

    localparam longint QONE        = 65536;
    localparam longint S32MAX      = 64'sd2147483647;
    localparam longint S32MIN      = -64'sd2147483648;
    localparam int     CYCLE_LIMIT = 6000000;

    typedef struct {
        logic signed [31:0] target;
        logic signed [31:0] measured;
        logic [15:0]        dt;
        logic [11:0]        throttle;
        logic               armed;
    } rate_sample_t;

    typedef struct {
        logic signed [31:0] drive;
        logic               integrating;
    } pid_result_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic signed [31:0]  s_target_rate;
    logic signed [31:0]  s_measured_rate;
    logic [15:0]         s_time_step;
    logic [11:0]         s_throttle_level;
    logic                s_armed;
    logic                m_valid;
    logic                m_ready;
    logic signed [31:0]  m_drive;
    logic                m_integrating;

    rate_pid_filtered_derivative_core i_dut (.*);

    rate_sample_t sample_queue[$];
    pid_result_t  drive_queue[$];
    rate_sample_t cur_sample;
    int           errors;
    int           cycles;

    // model copy of registers and state
    longint kf, kp, ki, kd, dcoef, ilim, elim, thrmin;
    longint integ_acc, prev_neg_meas, filt_deriv;

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_target_rate = '0;
        s_measured_rate = '0;
        s_time_step = 16'd1;
        s_throttle_level = '0;
        s_armed = 1'b0;
        m_ready = 1'b0;
        errors = 0;
        cycles = 0;
        kf = 0; kp = 2523136; ki = 33; kd = 33; dcoef = 13107;
        ilim = 196608; elim = 205783; thrmin = 100;
        integ_acc = 0; prev_neg_meas = 0; filt_deriv = 0;
    end

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint sat32(longint x);
        if (x > S32MAX) return S32MAX;
        if (x < S32MIN) return S32MIN;
        return x;
    endfunction

    function automatic pid_result_t predict_drive(rate_sample_t s);
        pid_result_t r;
        longint err, sum, aerr, neg, diff, dt, rate, coef, filt;
        longint brk, hi, lo, pterm, ff, aint;
        dt = s.dt;
        err = longint'(s.target) - longint'(s.measured);
        sum = integ_acc + ((err * dt) >>> 16);
        if (sum > ilim) sum = ilim;
        if (sum < -ilim) sum = -ilim;
        aerr = (err < 0) ? -err : err;
        if (aerr > elim) sum = 0;
        if (longint'(s.throttle) < thrmin) sum = 0;
        if (!s.armed) sum = 0;
        integ_acc = sum;
        neg = sat32(-longint'(s.measured));
        diff = neg - prev_neg_meas;
        prev_neg_meas = neg;
        if (dt == 0) dt = 1;
        rate = sat32((diff * QONE) / dt);
        coef = (dcoef > QONE) ? QONE : dcoef;
        filt = (coef * rate + (QONE - coef) * filt_deriv) >>> 16;
        filt_deriv = filt;
        brk = err + ((ki * integ_acc) >>> 16) + ((kd * filt) >>> 16);
        hi = brk >>> 16;
        lo = brk - hi * QONE;
        pterm = kp * hi + ((kp * lo) >>> 16);
        ff = (kf * longint'(s.target)) >>> 16;
        r.drive = 32'(sat32(ff + pterm));
        aint = (integ_acc < 0) ? -integ_acc : integ_acc;
        r.integrating = (aint >= 3277);
        return r;
    endfunction

    task automatic write_reg(cfg_idx_t idx, longint val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CfgDataW'(val);
        case (idx)
            CFG_FF_GAIN:   kf = val & 64'hFFFFFF;
            CFG_P_GAIN:    kp = val & 64'h3FFFFFF;
            CFG_I_GAIN:    ki = val & 64'hFFFFFF;
            CFG_D_GAIN:    kd = val & 64'hFFFFFF;
            CFG_D_COEF:    dcoef = val & 64'h1FFFF;
            CFG_I_LIMIT:   ilim = val & 64'h7FFFFFFF;
            CFG_ERR_LIMIT: elim = val & 64'h7FFFFFFF;
            default:       thrmin = val & 64'hFFF;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(longint f, longint p, longint i, longint d,
                             longint c, longint il, longint el, longint tm);
        write_reg(CFG_FF_GAIN, f);
        write_reg(CFG_P_GAIN, p);
        write_reg(CFG_I_GAIN, i);
        write_reg(CFG_D_GAIN, d);
        write_reg(CFG_D_COEF, c);
        write_reg(CFG_I_LIMIT, il);
        write_reg(CFG_ERR_LIMIT, el);
        write_reg(CFG_THR_MIN, tm);
    endtask

    task automatic push_sample(longint t, longint m, int dt, int thr, bit arm);
        rate_sample_t s;
        s.target = 32'(t);
        s.measured = 32'(m);
        s.dt = 16'(dt);
        s.throttle = 12'(thr);
        s.armed = arm;
        sample_queue.push_back(s);
    endtask

    task automatic push_random(int n);
        rate_sample_t s;
        int kind;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                s.target = $urandom;
                s.measured = $urandom;
                s.dt = 16'($urandom_range(1, 65535));
                s.throttle = 12'($urandom);
                s.armed = 1'($urandom);
            end else begin
                s.target = $signed($urandom_range(0, 524288)) - 262144;
                s.measured = s.target + $signed($urandom_range(0, 400000)) - 200000;
                s.dt = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535))
                                                   : 16'($urandom_range(1, 2000));
                s.throttle = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 150))
                                                         : 12'($urandom_range(100, 4095));
                s.armed = ($urandom_range(0, 9) != 0);
            end
            sample_queue.push_back(s);
        end
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (sample_queue.size() != 0 || s_valid || drive_queue.size() != 0);
        repeat (300) @(posedge aclk);
    endtask

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                drive_queue.push_back(predict_drive(cur_sample));
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (sample_queue.size() != 0) begin
                    cur_sample = sample_queue.pop_front();
                    s_target_rate <= cur_sample.target;
                    s_measured_rate <= cur_sample.measured;
                    s_time_step <= cur_sample.dt;
                    s_throttle_level <= cur_sample.throttle;
                    s_armed <= cur_sample.armed;
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 6);
                        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 250)
                                                               : $urandom_range(0, 3);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor with its own stall pattern
    int stall_mode = 0;
    always @(posedge aclk) begin
        pid_result_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (cycles % 512 == 0) stall_mode = $urandom_range(0, 3);
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (drive_queue.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result drive=%0d", m_drive);
                end else begin
                    e = drive_queue.pop_front();
                    if (m_drive !== e.drive || m_integrating !== e.integrating) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: drive exp %0d got %0d, integ exp %0b got %0b",
                                     e.drive, m_drive, e.integrating, m_integrating);
                    end
                end
            end
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 0);
                2: m_ready <= ($urandom_range(0, 15) == 0);
                default: m_ready <= ((cycles % 300) > 150);
            endcase
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // reset defaults, directed corners
        push_sample(0, 0, 1, 4095, 1);
        push_sample(S32MAX, S32MIN, 65535, 4095, 1);
        push_sample(S32MIN, S32MAX, 1, 4095, 1);
        push_sample(0, S32MIN, 1, 4095, 1);
        push_sample(0, S32MAX, 0, 4095, 1);
        push_sample(65536, 0, 0, 4095, 1);
        push_sample(100000, 0, 65535, 4095, 1);
        push_sample(100000, 0, 65535, 4095, 1);
        push_sample(100000, 0, 65535, 4095, 1);
        push_sample(-100000, 0, 65535, 4095, 1);
        push_sample(-100000, 0, 65535, 4095, 1);
        push_sample(-100000, 0, 65535, 4095, 1);
        push_sample(205783, 0, 30000, 200, 1);
        push_sample(205784, 0, 30000, 200, 1);
        push_sample(100000, 0, 65535, 99, 1);
        push_sample(100000, 0, 65535, 100, 1);
        push_sample(100000, 0, 65535, 100, 0);
        push_sample(-1, 1, 1, 0, 0);
        push_sample(S32MAX, S32MAX, 65535, 4095, 1);
        push_sample(S32MIN, S32MIN, 1, 4095, 1);
        push_random(200);
        drain();
        write_all(64'hFFFFFF, 64'h3FFFFFF, 64'hFFFFFF, 64'hFFFFFF, 131071,
                  64'h7FFFFFFF, 64'h7FFFFFFF, 4095);
        push_sample(S32MAX, S32MIN, 65535, 4095, 1);
        push_sample(S32MIN, S32MAX, 1, 4095, 1);
        push_random(200);
        drain();
        write_all(0, 0, 0, 0, 0, 0, 0, 0);
        push_random(200);
        drain();
        write_all(0, 65536, 65536, 65536, 65536, 196608, 205783, 0);
        push_random(200);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            write_all($urandom_range(0, 200000), $urandom_range(0, 4000000),
                      $urandom_range(0, 500000), $urandom_range(0, 200000),
                      $urandom_range(0, 65536), $urandom_range(0, 1000000),
                      $urandom_range(0, 1000000), $urandom_range(0, 4095));
            push_random(200);
            drain();
        end
        if (errors == 0 && drive_queue.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/rpfd_pkg.sv
design/rate_pid_filtered_derivative_core.sv
bench/tb_rate_pid_filtered_derivative_core.sv
